[rtl/core/lzw_decoder_core_assert.svh]
// Assertion macros for the LZW decoder checker.
`ifndef LZW_DECODER_CORE_ASSERT_SVH
`define LZW_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clock, quiet during reset.
`define LZWD_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, quiet during reset.
`define LZWD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/lzwd_pkg.sv]
// Package: shared constants, types and state codes of the LZW decoder.
`default_nettype none

package lzwd_pkg;

   localparam int CODE_W        = 12;
   localparam int BYTE_W        = 8;
   localparam int LITERALS      = 256;
   localparam int DICT_SIZE_DEF = 4096;
   localparam int MAX_LEN_DEF   = 64;
   localparam int QUEUE_DEPTH   = 2;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_TOO_HIGH = 2'd1,
      STATUS_TOO_LONG = 2'd2
   } lzwd_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_WALK,
      ST_PRIME,
      ST_EMIT,
      ST_ERR
   } lzwd_state_type;

   // One queued code, classified by the front end.
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              start;
      logic              is_lit;
   } lzwd_item_type;

endpackage

`default_nettype wire

[rtl/core/lzwd_ifs.sv]
// Interfaces: code request channel and decoded byte response channel.
`default_nettype none

interface lzwd_req_if;
   logic                         valid;
   logic                         ready;
   logic [lzwd_pkg::CODE_W-1:0]  code_in;
   logic                         stream_start;

   modport source (output valid, output code_in, output stream_start, input ready);
   modport sink   (input valid, input code_in, input stream_start, output ready);
endinterface

interface lzwd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [lzwd_pkg::BYTE_W-1:0]  out_byte;
   logic                         last_byte;
   logic [1:0]                   status;

   modport source (output valid, output out_byte, output last_byte, output status,
                   input ready);
   modport sink   (input valid, input out_byte, input last_byte, input status,
                   output ready);
endinterface

`default_nettype wire

[rtl/core/lzwd_front.sv]
// Front end: takes code words, tags literals and queues them for the back end.
`default_nettype none

module lzwd_front (
   input  wire logic            clock,
   input  wire logic            reset,
   lzwd_req_if.sink             req_chan,
   output lzwd_pkg::lzwd_item_type head,
   output logic                 head_valid,
   input  wire logic            head_pop
);
   import lzwd_pkg::*;

   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   lzwd_item_type     queue_mem [QUEUE_DEPTH];
   logic [QW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              push;
   logic              pop;
   lzwd_item_type     new_item;

   assign req_chan.ready = (count_ff != CW'(QUEUE_DEPTH));
   assign push           = req_chan.valid && req_chan.ready;
   assign pop            = head_pop && head_valid;
   assign head_valid     = (count_ff != '0);
   assign head           = queue_mem[rd_ptr_ff];

   always_comb begin
      new_item.code   = req_chan.code_in;
      new_item.start  = req_chan.stream_start;
      new_item.is_lit = (req_chan.code_in < CODE_W'(LITERALS));
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

[rtl/core/lzwd_back.sv]
// Back end: dictionary, prefix-chain walk, byte stack and output register.
`default_nettype none

module lzwd_back #(
   parameter int DICT_SIZE = lzwd_pkg::DICT_SIZE_DEF,
   parameter int MAX_LEN   = lzwd_pkg::MAX_LEN_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  lzwd_pkg::lzwd_item_type head,
   input  wire logic              head_valid,
   output logic                   head_pop,
   lzwd_rsp_if.source             rsp_chan
);
   import lzwd_pkg::*;

   localparam int AW    = $clog2(DICT_SIZE);
   localparam int NFC_W = AW + 1;
   localparam int CMP_W = (NFC_W > CODE_W) ? NFC_W : CODE_W;
   localparam int LEN_W = $clog2(MAX_LEN + 2);
   localparam int SW    = $clog2(MAX_LEN);

   // Dictionary and byte stack
   logic [CODE_W-1:0] dict_prefix [DICT_SIZE];
   logic [BYTE_W-1:0] dict_suffix [DICT_SIZE];
   logic [LEN_W-1:0]  dict_length [DICT_SIZE];
   logic [BYTE_W-1:0] stk_mem     [MAX_LEN];

   logic [CODE_W-1:0] rd_prefix_ff;
   logic [BYTE_W-1:0] rd_suffix_ff;
   logic [LEN_W-1:0]  rd_length_ff;
   logic [BYTE_W-1:0] stk_rd_ff;

   logic              dict_we;
   logic [AW-1:0]     dict_wa;
   logic              stk_we;
   logic [SW-1:0]     stk_wa;
   logic [BYTE_W-1:0] stk_wd;

   lzwd_state_type    state_ff, state_in;
   logic [NFC_W-1:0]  nfc_ff, nfc_in;
   logic              hp_ff, hp_in;
   logic [CODE_W-1:0] prev_ff, prev_in;
   logic [BYTE_W-1:0] pfirst_ff, pfirst_in;
   logic [LEN_W-1:0]  plen_ff, plen_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic              kwk_ff, kwk_in;
   logic              lit_ff, lit_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic [CODE_W-1:0] node_ff, node_in;
   logic [SW-1:0]     idx_ff, idx_in;
   lzwd_status_type   err_ff, err_in;

   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;
   lzwd_status_type   out_status_ff, out_status_in;

   logic              out_free;
   logic [NFC_W-1:0]  start_nfc;
   logic              start_hp;
   logic              kwk;
   logic              too_high;
   logic [LEN_W-1:0]  len_calc;
   logic              last_idx;

   assign out_free = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      start_nfc = head.start ? NFC_W'(LITERALS) : nfc_ff;
      start_hp  = head.start ? 1'b0 : hp_ff;
      kwk       = (CMP_W'(head.code) == CMP_W'(start_nfc));
      too_high  = (CMP_W'(head.code) > CMP_W'(start_nfc)) ||
                  (kwk && (!start_hp || (start_nfc >= NFC_W'(DICT_SIZE))));
      if (kwk_ff) begin
         len_calc = plen_ff + 1'b1;
      end else if (lit_ff) begin
         len_calc = LEN_W'(1);
      end else begin
         len_calc = rd_length_ff;
      end
      last_idx = (LEN_W'(idx_ff) == (len_ff - 1'b1));
   end

   always_comb begin
      state_in      = state_ff;
      nfc_in        = nfc_ff;
      hp_in         = hp_ff;
      prev_in       = prev_ff;
      pfirst_in     = pfirst_ff;
      plen_in       = plen_ff;
      code_in       = code_ff;
      kwk_in        = kwk_ff;
      lit_in        = lit_ff;
      len_in        = len_ff;
      pos_in        = pos_ff;
      node_in       = node_ff;
      idx_in        = idx_ff;
      err_in        = err_ff;
      head_pop      = 1'b0;
      dict_we       = 1'b0;
      dict_wa       = AW'(nfc_ff);
      stk_we        = 1'b0;
      stk_wa        = '0;
      stk_wd        = '0;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;

      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               // Apply the stream restart even when the code then fails.
               head_pop = 1'b1;
               nfc_in   = start_nfc;
               hp_in    = start_hp;
               code_in  = head.code;
               kwk_in   = kwk;
               lit_in   = head.is_lit;
               node_in  = kwk ? prev_ff : head.code;
               if (too_high) begin
                  err_in   = STATUS_TOO_HIGH;
                  state_in = ST_ERR;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (len_calc > LEN_W'(MAX_LEN)) begin
               err_in   = STATUS_TOO_LONG;
               state_in = ST_ERR;
            end else begin
               len_in = len_calc;
               if (kwk_ff) begin
                  // The repeated code ends in its own first byte.
                  pos_in = len_calc - 1'b1;
                  stk_we = 1'b1;
                  stk_wa = SW'(len_calc - 1'b1);
                  stk_wd = pfirst_ff;
               end else begin
                  pos_in = len_calc;
               end
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if ((pos_ff > LEN_W'(1)) && (node_ff >= CODE_W'(LITERALS))) begin
               stk_we  = 1'b1;
               stk_wa  = SW'(pos_ff - 1'b1);
               stk_wd  = rd_suffix_ff;
               pos_in  = pos_ff - 1'b1;
               node_in = rd_prefix_ff;
            end else begin
               stk_we = 1'b1;
               stk_wa = '0;
               stk_wd = node_ff[BYTE_W-1:0];
               if (hp_ff && (nfc_ff < NFC_W'(DICT_SIZE))) begin
                  dict_we = 1'b1;
                  nfc_in  = nfc_ff + 1'b1;
               end
               prev_in   = code_ff;
               pfirst_in = node_ff[BYTE_W-1:0];
               plen_in   = len_ff;
               hp_in     = 1'b1;
               idx_in    = '0;
               state_in  = ST_PRIME;
            end
         end
         ST_PRIME: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_byte_in   = stk_rd_ff;
               out_last_in   = last_idx;
               out_status_in = STATUS_OK;
               if (last_idx) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_ERR: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_byte_in   = '0;
               out_last_in   = 1'b1;
               out_status_in = err_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nfc_ff       <= NFC_W'(LITERALS);
         hp_ff        <= 1'b0;
         prev_ff      <= '0;
         pfirst_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nfc_ff       <= nfc_in;
         hp_ff        <= hp_in;
         prev_ff      <= prev_in;
         pfirst_ff    <= pfirst_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      plen_ff       <= plen_in;
      code_ff       <= code_in;
      kwk_ff        <= kwk_in;
      lit_ff        <= lit_in;
      len_ff        <= len_in;
      pos_ff        <= pos_in;
      node_ff       <= node_in;
      idx_ff        <= idx_in;
      err_ff        <= err_in;
      out_byte_ff   <= out_byte_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
   end

   // Dictionary: one write port, one registered read tracking the chain node.
   always_ff @(posedge clock) begin
      if (dict_we) begin
         dict_prefix[dict_wa] <= prev_ff;
         dict_suffix[dict_wa] <= node_ff[BYTE_W-1:0];
         dict_length[dict_wa] <= plen_ff + 1'b1;
      end
      rd_prefix_ff <= dict_prefix[AW'(node_in)];
      rd_suffix_ff <= dict_suffix[AW'(node_in)];
      rd_length_ff <= dict_length[AW'(node_in)];
   end

   // Byte stack: filled back to front, read front to back.
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_wa] <= stk_wd;
      end
      stk_rd_ff <= stk_mem[idx_in];
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.out_byte  = out_byte_ff;
   assign rsp_chan.last_byte = out_last_ff;
   assign rsp_chan.status    = out_status_ff;

endmodule

`default_nettype wire

[rtl/core/lzw_decoder_core.sv]
// LZW decoder for 12-bit codes: front queue, back-end decoder and output register.
//
// Usage:
//   req_chan carries one word per code: code_in and stream_start. Raise
//   stream_start on the first code of a stream to empty the dictionary.
//   rsp_chan returns one word per decoded byte (out_byte), with last_byte
//   set on the final byte of the code's string and status 0. A code above
//   the next free code, or a repeated-code reference with no previous code
//   or a full dictionary, returns one word with status 1; a string longer
//   than MAX_LEN returns one word with status 2. Error words carry byte 0
//   and last_byte 1.
//   The decoder takes one code at a time: it checks the string length,
//   walks the prefix chain one dictionary entry per cycle onto the byte
//   stack, primes the stack read, then reads the stack once per emitted
//   byte, waiting while the receiver stalls. It takes the next code only
//   after the last byte or the error word has been sent.
//   A two-word queue accepts codes while the decoder is busy.
//   Reset empties the queue and the output register and restarts the
//   dictionary at code 256; no clearing pass is needed.
//   When the receiver stalls, the output register holds its word, the
//   decoder waits, and the queue keeps accepting until full.
`default_nettype none

module lzw_decoder_core #(
   parameter int DICT_SIZE = lzwd_pkg::DICT_SIZE_DEF,
   parameter int MAX_LEN   = lzwd_pkg::MAX_LEN_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lzwd_req_if.sink   req_chan,
   lzwd_rsp_if.source rsp_chan
);
   import lzwd_pkg::*;

   // Queue head handed from front to back
   lzwd_item_type head;
   logic          head_valid;
   logic          head_pop;

   // Accept, classify and queue incoming code words.
   lzwd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop)
   );

   // Decode one queued code at a time and drive the output register.
   lzwd_back #(
      .DICT_SIZE (DICT_SIZE),
      .MAX_LEN   (MAX_LEN)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

[rtl/core/lzwd_checker.sv]
// Checker: port-level assertions on the LZW decoder, bound to the top level.
`default_nettype none
`include "lzw_decoder_core_assert.svh"

module lzwd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_last_byte,
   input wire logic [1:0] rsp_status
);
   import lzwd_pkg::*;

   // Hold a stalled word unchanged.
   `LZWD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last_byte) && $stable(rsp_status), "stalled response word changed")

   // An error word is a single closing word with a zero byte.
   `LZWD_ASSERT_IMP(a_err_shape, rsp_valid && (rsp_status != STATUS_OK), rsp_last_byte && (rsp_out_byte == 8'd0), "error word not a lone zero last byte")

   // No word leaves in the first cycle after reset.
   `LZWD_ASSERT_IMP(a_reset_quiet, $fell(reset), !rsp_valid, "response valid right after reset")

endmodule

bind lzw_decoder_core lzwd_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_out_byte  (rsp_chan.out_byte),
   .rsp_last_byte (rsp_chan.last_byte),
   .rsp_status    (rsp_chan.status)
);

`default_nettype wire
